// ===== rtl/core/lkvc_pkg.sv =====
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared types and constants for the LRU key-value cache: request kinds,
// controller states, the controller-to-datapath command group and the
// fixed field widths.
// ----------------------------------------------------------------------------
package lkvc_pkg;

   // Fixed field widths
   localparam int VALUE_BITS = 32;
   localparam int CAP_BITS   = 5;

   // Capacity register value after reset
   localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

   // Request kind carried on req_tuser
   typedef enum logic {
      REQ_GET = 1'b0,
      REQ_PUT = 1'b1
   } req_kind_type;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_UPDATE
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;    // capture the request beat
      logic lookup;  // run the key compare and register its results
      logic commit;  // update the table and load the response register
   } cmd_type;

endpackage

// ===== rtl/core/lkvc_ctrl.sv =====
// ----------------------------------------------------------------------------
// lkvc_ctrl
// Request sequencer: takes a request beat, steps it through the lookup and
// update cycles and owns the valid flag of the response register.
// ----------------------------------------------------------------------------
module lkvc_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output lkvc_pkg::cmd_type cmd
);
   import lkvc_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      can_commit;
   logic      accept;

   // State register and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and command outputs
   always_comb begin
      can_commit = (state_ff == ST_UPDATE) && (!rsp_valid_ff || rsp_tready);
      req_tready = (state_ff == ST_IDLE) || can_commit;
      accept     = req_tvalid && req_tready;
      state_in   = state_ff;
      cmd.load   = accept;
      cmd.lookup = 1'b0;
      cmd.commit = can_commit;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = ST_UPDATE;
         end
         ST_UPDATE: begin
            // hold here while the previous response has not been taken
            if (can_commit) state_in = accept ? ST_LOOKUP : ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      if (can_commit)      rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
      else                 rsp_valid_in = rsp_valid_ff;
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ===== rtl/core/lkvc_dpath.sv =====
// ----------------------------------------------------------------------------
// lkvc_dpath
// Cache datapath: key and recency tables in flops, value memory, parallel
// key compare, LRU victim and free slot search, and the response register.
// ----------------------------------------------------------------------------
module lkvc_dpath #(
   parameter int ENTRIES  = 16,
   parameter int KEY_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  lkvc_pkg::cmd_type                  cmd,
   input  logic                               csr_wen,
   input  logic [lkvc_pkg::CAP_BITS-1:0]      csr_wdata,
   input  logic                               req_type,
   input  logic [KEY_BITS-1:0]                req_key,
   input  logic [lkvc_pkg::VALUE_BITS-1:0]    req_write_value,
   output logic                               rsp_found,
   output logic [lkvc_pkg::VALUE_BITS-1:0]    rsp_read_value,
   output logic                               rsp_evicted,
   output logic [KEY_BITS-1:0]                rsp_evicted_key
);
   import lkvc_pkg::*;

   localparam int IDX_W  = $clog2(ENTRIES);
   localparam int RANK_W = $clog2(ENTRIES);
   localparam int CNT_W  = $clog2(ENTRIES + 1);
   localparam int CMP_W  = (CNT_W > CAP_BITS) ? CNT_W : CAP_BITS;

   // Captured request
   logic                  type_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [VALUE_BITS-1:0] wval_ff;

   // Table state
   logic [KEY_BITS-1:0]   keys_ff [ENTRIES];
   logic [RANK_W-1:0]     rank_ff [ENTRIES];
   logic [RANK_W-1:0]     rank_in [ENTRIES];
   logic [ENTRIES-1:0]    valid_ff, valid_in;
   logic [CNT_W-1:0]      used_ff, used_in;
   logic [CAP_BITS-1:0]   cap_ff;
   logic [VALUE_BITS-1:0] value_mem [ENTRIES];
   logic [VALUE_BITS-1:0] rdata_ff;

   // Lookup results
   logic                  hit, evict, ins_ok;
   logic [IDX_W-1:0]      hit_slot, victim_slot, ins_slot;
   logic [ENTRIES-1:0]    hit_vec, victim_vec, free_vec;
   logic [CMP_W-1:0]      cap_ext, cap_eff;
   logic                  is_put;

   logic                  hit_ff, evict_ff, ins_ok_ff;
   logic [IDX_W-1:0]      hit_slot_ff, victim_ff, ins_slot_ff;
   logic [RANK_W-1:0]     old_rank_ff;
   logic [KEY_BITS-1:0]   evkey_ff;

   logic                  mem_we;
   logic [IDX_W-1:0]      mem_waddr;

   assign is_put = (type_ff == REQ_PUT);

   // Request capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         type_ff <= req_type;
         key_ff  <= req_key;
         wval_ff <= req_write_value;
      end
   end

   // Capacity register
   always_ff @(posedge clock) begin
      if (reset)        cap_ff <= CAP_RESET;
      else if (csr_wen) cap_ff <= csr_wdata;
   end

   // Effective capacity: zero reads as one, above the table size saturates
   always_comb begin
      cap_ext = CMP_W'(cap_ff);
      if (cap_ff == '0)                    cap_eff = CMP_W'(1);
      else if (cap_ext > CMP_W'(ENTRIES))  cap_eff = CMP_W'(ENTRIES);
      else                                 cap_eff = cap_ext;
   end

   // Parallel compare, LRU victim and lowest free slot
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         hit_vec[i]    = valid_ff[i] && (keys_ff[i] == key_ff);
         victim_vec[i] = valid_ff[i] && (rank_ff[i] == RANK_W'(used_ff - CNT_W'(1)));
      end
      hit = |hit_vec;
      evict = is_put && !hit && (used_ff != '0) && (CMP_W'(used_ff) >= cap_eff);
      free_vec = ~valid_ff | (evict ? victim_vec : '0);
      ins_ok = |free_vec;
      hit_slot    = '0;
      victim_slot = '0;
      ins_slot    = '0;
      // downward scan so the lowest index wins
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (hit_vec[i])    hit_slot    = IDX_W'(i);
         if (victim_vec[i]) victim_slot = IDX_W'(i);
         if (free_vec[i])   ins_slot    = IDX_W'(i);
      end
   end

   // Lookup result registers
   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         hit_ff      <= hit;
         hit_slot_ff <= hit_slot;
         old_rank_ff <= rank_ff[hit_slot];
         evict_ff    <= evict;
         victim_ff   <= victim_slot;
         evkey_ff    <= keys_ff[victim_slot];
         ins_slot_ff <= ins_slot;
         ins_ok_ff   <= ins_ok && is_put && !hit;
      end
   end

   // Table update on commit
   always_comb begin
      valid_in = valid_ff;
      rank_in  = rank_ff;
      used_in  = used_ff;
      if (cmd.commit) begin
         if (hit_ff) begin
            // move the hit entry to the front, shift the more recent ones back
            for (int i = 0; i < ENTRIES; i++) begin
               if (valid_ff[i] && (rank_ff[i] < old_rank_ff))
                  rank_in[i] = rank_ff[i] + RANK_W'(1);
            end
            rank_in[hit_slot_ff] = '0;
         end else if (ins_ok_ff) begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (valid_ff[i] && !(evict_ff && (IDX_W'(i) == victim_ff)))
                  rank_in[i] = rank_ff[i] + RANK_W'(1);
            end
            if (evict_ff) begin
               valid_in[victim_ff] = 1'b0;
               rank_in[victim_ff]  = '0;
            end
            valid_in[ins_slot_ff] = 1'b1;
            rank_in[ins_slot_ff]  = '0;
            if (!evict_ff) used_in = used_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         used_ff  <= '0;
         for (int i = 0; i < ENTRIES; i++) rank_ff[i] <= '0;
      end else begin
         valid_ff <= valid_in;
         used_ff  <= used_in;
         rank_ff  <= rank_in;
      end
   end

   // Key write for a new entry
   always_ff @(posedge clock) begin
      if (cmd.commit && !hit_ff && ins_ok_ff) keys_ff[ins_slot_ff] <= key_ff;
   end

   // Value memory: one write port, one registered read port
   assign mem_we    = cmd.commit && is_put && (hit_ff || ins_ok_ff);
   assign mem_waddr = hit_ff ? hit_slot_ff : ins_slot_ff;

   always_ff @(posedge clock) begin
      if (mem_we) value_mem[mem_waddr] <= wval_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup) rdata_ff <= value_mem[hit_slot];
   end

   // Response register
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_found       <= hit_ff;
         rsp_read_value  <= (hit_ff && !is_put) ? rdata_ff : '0;
         rsp_evicted     <= evict_ff;
         rsp_evicted_key <= evict_ff ? evkey_ff : '0;
      end
   end

endmodule

// ===== rtl/core/lru_key_value_cache.sv =====
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Flow: an accepted request beat is captured; a lookup step does the parallel
//   key compare and value memory read, an update step the recency update and
//   write and the response load, which waits until the response side is free.
//   A new beat is taken only when idle or with that update, not mid-request.
// Reset: synchronous, clears all valid marks, ranks and the entry count, and
//   sets the capacity to 16; keys and values are not cleared.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
   parameter int ENTRIES  = 16,
   parameter int KEY_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   // request channel
   input  logic req_tvalid,
   output logic req_tready,
   // tdata: key, write_value
   input  logic [((KEY_BITS + lkvc_pkg::VALUE_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   // tuser: req_type
   input  logic req_tuser,
   // response channel
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // tdata: read_value, evicted_key
   output logic [((KEY_BITS + lkvc_pkg::VALUE_BITS + 7) / 8) * 8 - 1:0] rsp_tdata,
   // tuser: found, evicted
   output logic [1:0] rsp_tuser,
   // capacity register
   input  logic csr_wen,
   input  logic [lkvc_pkg::CAP_BITS-1:0] csr_wdata
);
   import lkvc_pkg::*;

   localparam int DATA_W = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8;

   cmd_type               cmd;
   logic                  found, evicted;
   logic [VALUE_BITS-1:0] read_value;
   logic [KEY_BITS-1:0]   evicted_key;

   lkvc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   lkvc_dpath #(
      .ENTRIES  (ENTRIES),
      .KEY_BITS (KEY_BITS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .csr_wen         (csr_wen),
      .csr_wdata       (csr_wdata),
      .req_type        (req_tuser),
      .req_key         (req_tdata[KEY_BITS-1:0]),
      .req_write_value (req_tdata[KEY_BITS +: VALUE_BITS]),
      .rsp_found       (found),
      .rsp_read_value  (read_value),
      .rsp_evicted     (evicted),
      .rsp_evicted_key (evicted_key)
   );

   // Response beat packing
   assign rsp_tdata = DATA_W'({evicted_key, read_value});
   assign rsp_tuser = {evicted, found};

   // A hit never evicts
   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(found && evicted))
      else $error("response reports both a hit and an eviction");

   // No evicted key without an eviction
   a_evkey_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !evicted) |-> (evicted_key == '0))
      else $error("evicted key set without an eviction");

   // A miss returns no value
   a_miss_value_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !found) |-> (read_value == '0))
      else $error("value returned on a miss");

   // Each request takes its lookup step: no beat accepted right after another
   a_two_cycle: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted in back-to-back cycles");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for lru_key_value_cache. A queue-fed driver sends get
// and put beats; a shadow LRU table predicts each response at acceptance.
// The monitor checks responses in order. Several capacity settings run in
// turn, with random idle cycles on both sides.
// ----------------------------------------------------------------------------
module tb;
   import lkvc_pkg::*;

   localparam int ENTRIES  = 16;
   localparam int KEY_BITS = 16;
   localparam int DATA_W   = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8;

   typedef struct packed {
      req_kind_type          kind;
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value;
   } cache_req_type;

   typedef struct packed {
      logic                  found;
      logic [VALUE_BITS-1:0] read_value;
      logic                  evicted;
      logic [KEY_BITS-1:0]   evicted_key;
   } cache_rsp_type;

   logic              clock;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [DATA_W-1:0] req_tdata  = '0;   // key, write_value
   logic              req_tuser  = 1'b0; // req_type
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [DATA_W-1:0] rsp_tdata;         // read_value, evicted_key
   logic [1:0]        rsp_tuser;         // found, evicted
   logic              csr_wen    = 1'b0;
   logic [CAP_BITS-1:0] csr_wdata = '0;

   // Shadow copy of the cache table
   logic [KEY_BITS-1:0]   ent_key   [ENTRIES];
   logic [VALUE_BITS-1:0] ent_val   [ENTRIES];
   bit                    ent_valid [ENTRIES];
   int unsigned           ent_rank  [ENTRIES];
   int unsigned           used_count;
   logic [CAP_BITS-1:0]   cap_shadow;

   cache_req_type req_backlog[$];
   cache_rsp_type expected_outcomes[$];

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int mismatches    = 0;
   int sent_total    = 0;
   int hit_total     = 0;
   int evict_total   = 0;
   int phase_total   = 0;

   lru_key_value_cache #(
      .ENTRIES  (ENTRIES),
      .KEY_BITS (KEY_BITS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

   // ------------------------------------------------------------------
   // LRU table prediction
   // ------------------------------------------------------------------
   function automatic void clear_table();
      for (int i = 0; i < ENTRIES; i++) begin
         ent_valid[i] = 1'b0;
         ent_rank[i]  = 0;
      end
      used_count = 0;
      cap_shadow = CAP_RESET;
   endfunction

   // slot becomes rank 0; entries that were more recent age by one
   function automatic void promote_entry(input int slot);
      int unsigned old_rank;
      old_rank = ent_rank[slot];
      for (int i = 0; i < ENTRIES; i++)
         if (ent_valid[i] && ent_rank[i] < old_rank) ent_rank[i]++;
      ent_rank[slot] = 0;
   endfunction

   function automatic cache_rsp_type cache_access(input cache_req_type r);
      cache_rsp_type o;
      int            hit_slot;
      int            victim;
      int            free_slot;
      int unsigned   victim_rank;
      int unsigned   limit;
      o        = '0;
      hit_slot = -1;
      for (int i = 0; i < ENTRIES; i++)
         if (hit_slot < 0 && ent_valid[i] && ent_key[i] == r.key) hit_slot = i;
      if (hit_slot >= 0) begin
         o.found = 1'b1;
         if (r.kind == REQ_GET) o.read_value = ent_val[hit_slot];
         else ent_val[hit_slot] = r.value;
         promote_entry(hit_slot);
         hit_total++;
      end else if (r.kind == REQ_PUT) begin
         // zero acts as one, anything above the table size saturates
         limit = (cap_shadow == 0) ? 1 : (cap_shadow > ENTRIES) ? ENTRIES : cap_shadow;
         if (used_count >= limit && used_count > 0) begin
            victim      = -1;
            victim_rank = 0;
            for (int i = 0; i < ENTRIES; i++)
               if (ent_valid[i] && (victim < 0 || ent_rank[i] >= victim_rank)) begin
                  victim      = i;
                  victim_rank = ent_rank[i];
               end
            o.evicted         = 1'b1;
            o.evicted_key     = ent_key[victim];
            ent_valid[victim] = 1'b0;
            ent_rank[victim]  = 0;
            used_count--;
            evict_total++;
         end
         free_slot = -1;
         for (int i = 0; i < ENTRIES; i++)
            if (free_slot < 0 && !ent_valid[i]) free_slot = i;
         if (free_slot >= 0) begin
            for (int i = 0; i < ENTRIES; i++)
               if (ent_valid[i]) ent_rank[i]++;
            ent_valid[free_slot] = 1'b1;
            ent_key[free_slot]   = r.key;
            ent_val[free_slot]   = r.value;
            ent_rank[free_slot]  = 0;
            used_count++;
         end
      end
      return o;
   endfunction

   // ------------------------------------------------------------------
   // Request driver
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      cache_req_type took;
      cache_req_type nxt;
      bit            moved;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         moved = req_tvalid && req_tready;
         if (moved) begin
            took.kind  = req_kind_type'(req_tuser);
            took.key   = req_tdata[KEY_BITS-1:0];
            took.value = req_tdata[KEY_BITS +: VALUE_BITS];
            expected_outcomes.insert(expected_outcomes.size(), cache_access(took));
            sent_total++;
         end
         if (!req_tvalid || moved) begin
            if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt        = req_backlog.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= nxt.kind;
               req_tdata  <= {nxt.value, nxt.key};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Response monitor
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      cache_rsp_type want;
      cache_rsp_type got;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.found       = rsp_tuser[0];
            got.evicted     = rsp_tuser[1];
            got.read_value  = rsp_tdata[VALUE_BITS-1:0];
            got.evicted_key = rsp_tdata[VALUE_BITS +: KEY_BITS];
            if (expected_outcomes.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: response beat with nothing outstanding: found=%0b "
                     , $time, got.found, "value=%h evicted=%0b key=%h",
                     got.read_value, got.evicted, got.evicted_key);
            end else begin
               want = expected_outcomes.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: mismatch exp found=%0b value=%h evicted=%0b key=%h | ",
                        $time, want.found, want.read_value, want.evicted,
                        want.evicted_key, "got found=%0b value=%h evicted=%0b key=%h",
                        got.found, got.read_value, got.evicted, got.evicted_key);
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // ------------------------------------------------------------------
   // Stimulus and phase control
   // ------------------------------------------------------------------
   task automatic add_req(input req_kind_type kind, input logic [KEY_BITS-1:0] key,
                          input logic [VALUE_BITS-1:0] value);
      cache_req_type r;
      r.kind  = kind;
      r.key   = key;
      r.value = value;
      req_backlog.insert(req_backlog.size(), r);
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (req_backlog.size() != 0 || req_tvalid || expected_outcomes.size() != 0);
   endtask

   task automatic write_capacity(input logic [CAP_BITS-1:0] v);
      @(posedge clock);
      csr_wen   <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_wen   <= 1'b0;
      cap_shadow = v;
      phase_total++;
   endtask

   // Mostly traffic on a small key set sized around the capacity, so hits,
   // updates and evictions all happen; the rest is random keys and types.
   task automatic queue_workload(input int count, input int pool_size);
      logic [KEY_BITS-1:0] pool[$];
      logic [KEY_BITS-1:0] k;
      req_kind_type        kind;
      for (int i = 0; i < pool_size; i++) pool.insert(pool.size(), KEY_BITS'($urandom));
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(99) < 85) begin
            k    = pool[$urandom_range(pool_size - 1)];
            kind = ($urandom_range(99) < 55) ? REQ_GET : REQ_PUT;
         end else begin
            k    = KEY_BITS'($urandom_range(65535));
            kind = $urandom_range(1) ? REQ_PUT : REQ_GET;
         end
         add_req(kind, k, $urandom);
      end
   endtask

   initial begin
      logic [CAP_BITS-1:0] cap_plan[14];
      int                  eff;
      cap_plan = '{5'd31, 5'd1, 5'd4, 5'd16, 5'd2, 5'd8, 5'd0,
                   5'd16, 5'd3, 5'd12, 5'd5, 5'd16, 5'd7, 5'd31};
      clear_table();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty lookup, extreme keys and values, update of a value
      add_req(REQ_GET, 16'h0000, 32'h0);
      add_req(REQ_PUT, 16'h0000, 32'h7FFF_FFFF);
      add_req(REQ_PUT, 16'hFFFF, 32'h8000_0000);
      add_req(REQ_GET, 16'hFFFF, 32'hFFFF_FFFF);
      add_req(REQ_GET, 16'h0000, 32'h0);
      add_req(REQ_PUT, 16'h0000, 32'hFFFF_FFFF);
      add_req(REQ_GET, 16'h0000, 32'h0);
      add_req(REQ_GET, 16'h1234, 32'h0);
      wait_drained();

      // Capacity lowered below the entries in use: a new key evicts only one
      write_capacity(5'd1);
      @(negedge clock);
      add_req(REQ_PUT, 16'h0001, 32'h0000_0001);
      add_req(REQ_PUT, 16'h0002, 32'h0000_0002);
      add_req(REQ_GET, 16'h0001, 32'h0);
      add_req(REQ_PUT, 16'h0001, 32'h5555_AAAA);
      add_req(REQ_GET, 16'hFFFF, 32'h0);
      wait_drained();

      // Zero capacity behaves as one
      write_capacity(5'd0);
      @(negedge clock);
      add_req(REQ_PUT, 16'h0003, 32'hAAAA_5555);
      add_req(REQ_PUT, 16'h0004, 32'h0000_0004);
      add_req(REQ_GET, 16'h0004, 32'h0);
      add_req(REQ_GET, 16'h0003, 32'h0);
      wait_drained();

      // Random phases: each idle style in turn, several capacities
      for (int p = 0; p < 14; p++) begin
         write_capacity(cap_plan[p]);
         @(negedge clock);
         case (p % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 61; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 61; end
            default: begin send_idle_pct = 23; stall_pct = 23; end
         endcase
         eff = (cap_plan[p] == 0) ? 1 : (cap_plan[p] > ENTRIES) ? ENTRIES : cap_plan[p];
         queue_workload(125, eff + $urandom_range(1, 4));
         wait_drained();
      end

      repeat (6) @(posedge clock);
      $display("Ran %0d requests across %0d capacity settings and four idle styles",
         sent_total, phase_total + 1);
      $display("Predicted %0d hits and %0d evictions; %0d response mismatches",
         hit_total, evict_total, mismatches);
      if (mismatches == 0 && expected_outcomes.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
